// ----- src/bru_pkg.sv -----
// Package for the branch resolution unit: opcode codes, operand constants
// and the stage-to-stage struct types. No dependencies.
`timescale 1ns / 1ps

package bru_pkg;

    localparam logic [5:0] OP_J2    = 6'd0;
    localparam logic [5:0] OP_J8    = 6'd6;
    localparam logic [5:0] OP_JB    = 6'd7;
    localparam logic [5:0] OP_JW    = 6'd8;
    localparam logic [5:0] OP_JS    = 6'd9;
    localparam logic [5:0] OP_CATCH = 6'd10;
    localparam logic [5:0] OP_JZ3   = 6'd11;
    localparam logic [5:0] OP_JZ4   = 6'd12;
    localparam logic [5:0] OP_JNZ3  = 6'd13;
    localparam logic [5:0] OP_JNZ4  = 6'd14;
    localparam logic [5:0] OP_JZB   = 6'd15;
    localparam logic [5:0] OP_JNZB  = 6'd16;
    localparam logic [5:0] OP_JEB   = 6'd17;
    localparam logic [5:0] OP_JNEB  = 6'd18;
    localparam logic [5:0] OP_JDEB  = 6'd19;
    localparam logic [5:0] OP_JDNEB = 6'd20;
    localparam logic [5:0] OP_JEP   = 6'd21;
    localparam logic [5:0] OP_JNEP  = 6'd22;
    localparam logic [5:0] OP_JEBB  = 6'd23;
    localparam logic [5:0] OP_JNEBB = 6'd24;
    localparam logic [5:0] OP_JLB   = 6'd25;
    localparam logic [5:0] OP_JLEB  = 6'd26;
    localparam logic [5:0] OP_JGB   = 6'd27;
    localparam logic [5:0] OP_JGEB  = 6'd28;
    localparam logic [5:0] OP_JULB  = 6'd29;
    localparam logic [5:0] OP_JULEB = 6'd30;
    localparam logic [5:0] OP_JUGB  = 6'd31;
    localparam logic [5:0] OP_JUGEB = 6'd32;
    localparam logic [5:0] OP_JIB   = 6'd33;
    localparam logic [5:0] OP_JIW   = 6'd34;

    localparam logic [3:0]  PAIR_MASK  = 4'hF;
    localparam logic [15:0] PAIR_BIAS  = 16'd4;
    localparam logic [15:0] SHORT_BIAS = 16'd2;
    localparam logic [15:0] SKIP3      = 16'd3;
    localparam logic [15:0] SKIP4      = 16'd4;

    localparam logic [2:0] POP_NONE   = 3'd0;
    localparam logic [2:0] POP_ONE    = 3'd1;
    localparam logic [2:0] POP_TWO    = 3'd2;
    localparam logic [2:0] POP_DOUBLE = 3'd4;

    typedef struct packed {
        logic        valid;
        logic        take;
        logic [15:0] base;
        logic [15:0] offset;
        logic [2:0]  pops;
        logic [15:0] tbase;
        logic [15:0] tidx;
    } bru_dec_t;

    typedef struct packed {
        logic        valid;
        logic        take;
        logic [15:0] target;
        logic [2:0]  pops;
        logic [15:0] taddr;
    } bru_res_t;

endpackage

// ----- src/bru_decode.sv -----
// First stage: opcode decode, stack compares and operand selection.
// Depends on bru_pkg.
`timescale 1ns / 1ps

module bru_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [5:0]          operation,
    input  logic [15:0]         saved_pc,
    input  logic [7:0]          code_byte_a,
    input  logic [7:0]          code_byte_b,
    input  logic [15:0]         code_word,
    input  logic [15:0]         top_word,
    input  logic [15:0]         next_word,
    input  logic [31:0]         top_long,
    input  logic [31:0]         next_long,
    input  logic [15:0]         table_word,
    output bru_pkg::bru_dec_t   dec
);

    logic              valid_reg;
    bru_pkg::bru_dec_t data_reg;
    bru_pkg::bru_dec_t data_next;

    logic [15:0] rel8;
    logic [15:0] rel8b;
    logic        top_zero;
    logic        eq16;
    logic        eq32;
    logic        slt;
    logic        ult;
    logic        eq_pair;
    logic        eq_byte;
    logic [15:0] entry;

    assign rel8     = {{8{code_byte_a[7]}}, code_byte_a};
    assign rel8b    = {{8{code_byte_b[7]}}, code_byte_b};
    assign top_zero = (top_word == 16'd0);
    assign eq16     = (next_word == top_word);
    assign eq32     = (next_long == top_long);
    assign slt      = ($signed(next_word) < $signed(top_word));
    assign ult      = (next_word < top_word);
    assign eq_pair  = (top_word == {12'd0, code_byte_a[7:4]});
    assign eq_byte  = (top_word == {8'd0, code_byte_a});
    assign entry    = next_word[0] ? {8'd0, table_word[7:0]} : {8'd0, table_word[15:8]};

    always_comb
    begin
        data_next        = '0;
        data_next.valid  = 1'b1;
        data_next.base   = saved_pc;
        data_next.offset = rel8;
        data_next.pops   = bru_pkg::POP_NONE;
        if (operation inside {[bru_pkg::OP_J2:bru_pkg::OP_J8]})
        begin
            data_next.take   = 1'b1;
            data_next.offset = {10'd0, operation} + bru_pkg::SHORT_BIAS;
        end
        else
        begin
            case (operation)
                bru_pkg::OP_JB:
                begin
                    data_next.take = 1'b1;
                end
                bru_pkg::OP_JW:
                begin
                    data_next.take   = 1'b1;
                    data_next.offset = code_word;
                end
                bru_pkg::OP_JS:
                begin
                    data_next.take   = 1'b1;
                    data_next.base   = 16'd0;
                    data_next.offset = top_word;
                    data_next.pops   = bru_pkg::POP_ONE;
                end
                bru_pkg::OP_CATCH:
                begin
                    data_next.take = 1'b0;
                end
                bru_pkg::OP_JZ3, bru_pkg::OP_JZ4:
                begin
                    data_next.take   = top_zero;
                    data_next.pops   = bru_pkg::POP_ONE;
                    data_next.offset = (operation == bru_pkg::OP_JZ3) ?
                                       bru_pkg::SKIP3 : bru_pkg::SKIP4;
                end
                bru_pkg::OP_JNZ3, bru_pkg::OP_JNZ4:
                begin
                    data_next.take   = !top_zero;
                    data_next.pops   = bru_pkg::POP_ONE;
                    data_next.offset = (operation == bru_pkg::OP_JNZ3) ?
                                       bru_pkg::SKIP3 : bru_pkg::SKIP4;
                end
                bru_pkg::OP_JZB:
                begin
                    data_next.take = top_zero;
                    data_next.pops = bru_pkg::POP_ONE;
                end
                bru_pkg::OP_JNZB:
                begin
                    data_next.take = !top_zero;
                    data_next.pops = bru_pkg::POP_ONE;
                end
                bru_pkg::OP_JEB:
                begin
                    data_next.take = eq16;
                    data_next.pops = bru_pkg::POP_TWO;
                end
                bru_pkg::OP_JNEB:
                begin
                    data_next.take = !eq16;
                    data_next.pops = bru_pkg::POP_TWO;
                end
                bru_pkg::OP_JDEB:
                begin
                    data_next.take = eq32;
                    data_next.pops = bru_pkg::POP_DOUBLE;
                end
                bru_pkg::OP_JDNEB:
                begin
                    data_next.take = !eq32;
                    data_next.pops = bru_pkg::POP_DOUBLE;
                end
                bru_pkg::OP_JEP, bru_pkg::OP_JNEP:
                begin
                    data_next.take   = (operation == bru_pkg::OP_JEP) ? eq_pair : !eq_pair;
                    data_next.pops   = bru_pkg::POP_ONE;
                    data_next.offset = {12'd0, code_byte_a[3:0] & bru_pkg::PAIR_MASK}
                                       + bru_pkg::PAIR_BIAS;
                end
                bru_pkg::OP_JEBB, bru_pkg::OP_JNEBB:
                begin
                    data_next.take   = (operation == bru_pkg::OP_JEBB) ? eq_byte : !eq_byte;
                    data_next.pops   = bru_pkg::POP_ONE;
                    data_next.offset = rel8b;
                end
                bru_pkg::OP_JLB:
                begin
                    data_next.take = slt;
                    data_next.pops = bru_pkg::POP_TWO;
                end
                bru_pkg::OP_JLEB:
                begin
                    data_next.take = slt || eq16;
                    data_next.pops = bru_pkg::POP_TWO;
                end
                bru_pkg::OP_JGB:
                begin
                    data_next.take = !(slt || eq16);
                    data_next.pops = bru_pkg::POP_TWO;
                end
                bru_pkg::OP_JGEB:
                begin
                    data_next.take = !slt;
                    data_next.pops = bru_pkg::POP_TWO;
                end
                bru_pkg::OP_JULB:
                begin
                    data_next.take = ult;
                    data_next.pops = bru_pkg::POP_TWO;
                end
                bru_pkg::OP_JULEB:
                begin
                    data_next.take = ult || eq16;
                    data_next.pops = bru_pkg::POP_TWO;
                end
                bru_pkg::OP_JUGB:
                begin
                    data_next.take = !(ult || eq16);
                    data_next.pops = bru_pkg::POP_TWO;
                end
                bru_pkg::OP_JUGEB:
                begin
                    data_next.take = !ult;
                    data_next.pops = bru_pkg::POP_TWO;
                end
                bru_pkg::OP_JIB:
                begin
                    data_next.take   = ult;
                    data_next.pops   = bru_pkg::POP_TWO;
                    data_next.offset = entry;
                    data_next.tbase  = code_word;
                    data_next.tidx   = {1'b0, next_word[15:1]};
                end
                bru_pkg::OP_JIW:
                begin
                    data_next.take   = ult;
                    data_next.pops   = bru_pkg::POP_TWO;
                    data_next.offset = table_word;
                    data_next.tbase  = code_word;
                    data_next.tidx   = next_word;
                end
                default:
                begin
                    data_next.take = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        dec       = data_reg;
        dec.valid = valid_reg;
    end

endmodule

// ----- src/bru_target.sv -----
// Second stage: target and table address adders.
// Depends on bru_pkg.
`timescale 1ns / 1ps

module bru_target
(
    input  logic                clk,
    input  logic                rst_n,
    input  bru_pkg::bru_dec_t   dec,
    output bru_pkg::bru_res_t   res
);

    logic              valid_reg;
    bru_pkg::bru_res_t data_reg;
    bru_pkg::bru_res_t data_next;

    always_comb
    begin
        data_next.valid  = 1'b1;
        data_next.take   = dec.take;
        data_next.target = dec.base + dec.offset;
        data_next.pops   = dec.pops;
        data_next.taddr  = dec.tbase + dec.tidx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dec.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec.valid)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        res       = data_reg;
        res.valid = valid_reg;
    end

endmodule

// ----- src/bru_output.sv -----
// Third stage: result formatting and the output register with its strobe.
// Depends on bru_pkg.
`timescale 1ns / 1ps

module bru_output
(
    input  logic                clk,
    input  logic                rst_n,
    input  bru_pkg::bru_res_t   res,
    output logic                done,
    output logic                taken,
    output logic [15:0]         new_pc,
    output logic [2:0]          words_popped,
    output logic [15:0]         table_address
);

    logic        done_reg;
    logic        taken_reg;
    logic [15:0] new_pc_reg;
    logic [2:0]  pops_reg;
    logic [15:0] taddr_reg;
    logic [15:0] new_pc_next;

    // drop the target of a jump that falls through
    assign new_pc_next = res.take ? res.target : 16'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            taken_reg  <= res.take;
            new_pc_reg <= new_pc_next;
            pops_reg   <= res.pops;
            taddr_reg  <= res.taddr;
        end
    end

    assign done          = done_reg;
    assign taken         = taken_reg;
    assign new_pc        = new_pc_reg;
    assign words_popped  = pops_reg;
    assign table_address = taddr_reg;

endmodule

// ----- src/branch_resolution_unit.sv -----
// Branch resolution unit: resolves one jump request per cycle.
// Each request passes the decode, target and output registers in turn; its
// result shows with done high, together with taken, new_pc and the pops.
// Throughput: one request per cycle; busy is always low, three register stages.
// Reset: rst_n clears all stage valid bits, so results in flight are lost; the
// receiver cannot stall. Depends on bru_pkg, bru_decode, bru_target, bru_output.
`timescale 1ns / 1ps

module branch_resolution_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [5:0]   operation,
    input  logic [15:0]  saved_pc,
    input  logic [7:0]   code_byte_a,
    input  logic [7:0]   code_byte_b,
    input  logic [15:0]  code_word,
    input  logic [15:0]  top_word,
    input  logic [15:0]  next_word,
    input  logic [31:0]  top_long,
    input  logic [31:0]  next_long,
    input  logic [15:0]  table_word,
    output logic         done,
    output logic         taken,
    output logic [15:0]  new_pc,
    output logic [2:0]   words_popped,
    output logic [15:0]  table_address
);

    bru_pkg::bru_dec_t dec;
    bru_pkg::bru_res_t res;
    logic              accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    bru_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .operation   (operation),
        .saved_pc    (saved_pc),
        .code_byte_a (code_byte_a),
        .code_byte_b (code_byte_b),
        .code_word   (code_word),
        .top_word    (top_word),
        .next_word   (next_word),
        .top_long    (top_long),
        .next_long   (next_long),
        .table_word  (table_word),
        .dec         (dec)
    );

    bru_target u_target
    (
        .clk   (clk),
        .rst_n (rst_n),
        .dec   (dec),
        .res   (res)
    );

    bru_output u_output
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .done          (done),
        .taken         (taken),
        .new_pc        (new_pc),
        .words_popped  (words_popped),
        .table_address (table_address)
    );

    a_request_completes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("request did not complete in three cycles");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a request");

    a_pops_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (words_popped == bru_pkg::POP_NONE || words_popped == bru_pkg::POP_ONE ||
                  words_popped == bru_pkg::POP_TWO || words_popped == bru_pkg::POP_DOUBLE))
        else $error("illegal pop count");

    a_taddr_indexed_only: assert property (@(posedge clk) disable iff (!rst_n)
        done && (table_address != 16'd0) |->
            ($past(operation, 3) == bru_pkg::OP_JIB || $past(operation, 3) == bru_pkg::OP_JIW))
        else $error("table address from a non-indexed jump");

endmodule
